// ===== rtl/core/xrp_pkg.sv =====
// ----------------------------------------------------------------------------
// xrp_pkg
// Types and constants shared by the xorshift/rotate generator and its seeder.
// ----------------------------------------------------------------------------
package xrp_pkg;

  localparam logic FUNC_RESEED = 1'b0;
  localparam logic FUNC_GEN    = 1'b1;

  localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;

  localparam int unsigned OUT_ROT   = 7;
  localparam int unsigned STATE_SHL = 9;
  localparam int unsigned STATE_ROT = 11;

  typedef struct packed {
    logic        func;
    logic [63:0] seed;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    logic        was_reseed;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seed_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seed_status_t;

  typedef enum logic [2:0] {
    SEED_IDLE,
    SEED_GAMMA,
    SEED_MUL_LL,
    SEED_MUL_HL,
    SEED_MUL_LH,
    SEED_POST,
    SEED_DONE
  } seed_state_t;

endpackage

// ===== rtl/core/xorshift_rotate_prng_with_seeding_unit.sv =====
// ----------------------------------------------------------------------------
// xorshift_rotate_prng_with_seeding_unit
// 128-bit xorshift/rotate random word generator with splitmix64 reseeding.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a transaction with func and seed. func generate
//   returns rotl(w0 + w3, 7) and advances the state; func reseed loads the
//   four state words from two splitmix64 steps on seed (all-zero -> w0 = 1).
//   Every transaction yields exactly one rsp transaction; a reseed returns
//   word 0 with was_reseed set.
// Timing / throughput:
//   Generate: rsp valid the cycle after acceptance, one per cycle while the
//   receiver keeps up and no reseed is in progress.
//   Reseed: rsp valid once both splitmix64 steps finish on the single shared
//   32x32 multiplier, which forms three partial products per 64-bit multiply,
//   four multiplies in all. req_stall stays high until then.
// Reset: state words become {1, 0, 0, 0}, no rsp pending.
// Receiver stall: rsp holds; req_stall rises while a result is stuck, so
// nothing is accepted until the output register can take the next one.
// ----------------------------------------------------------------------------
module xorshift_rotate_prng_with_seeding_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  xrp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output xrp_pkg::rsp_t rsp
);

  logic [31:0] gen_words [4];
  logic [31:0] gen_words_next [4];
  logic        rsp_valid_next;
  xrp_pkg::rsp_t rsp_next;

  xrp_pkg::seed_ctrl_t   seed_ctrl;
  xrp_pkg::seed_status_t seed_status;
  logic [127:0]          seed_words;

  logic        accept;
  logic        out_free;
  logic [31:0] sum;
  logic [31:0] gen_out;
  logic [31:0] t2, t3, n0, n1, n2, n3;

  xrp_seed u_seed (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (seed_ctrl),
    .seed   (req.seed),
    .status (seed_status),
    .words  (seed_words)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = seed_status.busy || !out_free;
  assign accept    = req_valid && !req_stall;

  assign seed_ctrl.start = accept && (req.func == xrp_pkg::FUNC_RESEED);
  assign seed_ctrl.ack   = seed_status.done && out_free;

  assign sum     = gen_words[0] + gen_words[3];
  assign gen_out = {sum[31-xrp_pkg::OUT_ROT:0], sum[31:32-xrp_pkg::OUT_ROT]};
  assign t2      = gen_words[2] ^ gen_words[0];
  assign t3      = gen_words[3] ^ gen_words[1];
  assign n1      = gen_words[1] ^ t2;
  assign n0      = gen_words[0] ^ t3;
  assign n2      = t2 ^ (gen_words[1] << xrp_pkg::STATE_SHL);
  assign n3      = {t3[31-xrp_pkg::STATE_ROT:0], t3[31:32-xrp_pkg::STATE_ROT]};

  always_comb begin
    gen_words_next = gen_words;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    if (accept && (req.func == xrp_pkg::FUNC_GEN)) begin
      gen_words_next[0] = n0;
      gen_words_next[1] = n1;
      gen_words_next[2] = n2;
      gen_words_next[3] = n3;
      rsp_next.word       = gen_out;
      rsp_next.was_reseed = 1'b0;
      rsp_valid_next      = 1'b1;
    end else if (seed_ctrl.ack) begin
      gen_words_next[0] = seed_words[31:0];
      gen_words_next[1] = seed_words[63:32];
      gen_words_next[2] = seed_words[95:64];
      gen_words_next[3] = seed_words[127:96];
      if (seed_words == '0) begin
        gen_words_next[0] = 32'd1;
      end
      rsp_next.word       = '0;
      rsp_next.was_reseed = 1'b1;
      rsp_valid_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      gen_words[0] <= 32'd1;
      gen_words[1] <= '0;
      gen_words[2] <= '0;
      gen_words[3] <= '0;
    end else begin
      rsp_valid <= rsp_valid_next;
      gen_words <= gen_words_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

// ===== rtl/core/xrp_seed.sv =====
// ----------------------------------------------------------------------------
// xrp_seed
// Two splitmix64 steps on one shared 32x32 multiplier; each 64-bit product
// is built from three partial products.
// ----------------------------------------------------------------------------
module xrp_seed (
  input  logic                  clk,
  input  logic                  rst,
  input  xrp_pkg::seed_ctrl_t   ctrl,
  input  logic [63:0]           seed,
  output xrp_pkg::seed_status_t status,
  output logic [127:0]          words
);

  xrp_pkg::seed_state_t state, state_next;

  logic [63:0] acc, acc_next;
  logic [63:0] v, v_next;
  logic [63:0] prod, prod_next;
  logic [63:0] res_a, res_a_next;
  logic [63:0] res_b, res_b_next;
  logic        mul_sel, mul_sel_next;
  logic        step, step_next;

  logic [63:0] mul_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] acc_sum;
  logic [63:0] mix_out;

  assign mul_c   = mul_sel ? xrp_pkg::MIX_MUL2 : xrp_pkg::MIX_MUL1;
  assign mul_a   = (state == xrp_pkg::SEED_MUL_HL) ? v[63:32] : v[31:0];
  assign mul_b   = (state == xrp_pkg::SEED_MUL_LH) ? mul_c[63:32] : mul_c[31:0];
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = acc + xrp_pkg::MIX_GAMMA;
  assign mix_out = prod ^ (prod >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xrp_pkg::SEED_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc     <= acc_next;
    v       <= v_next;
    prod    <= prod_next;
    res_a   <= res_a_next;
    res_b   <= res_b_next;
    mul_sel <= mul_sel_next;
    step    <= step_next;
  end

  always_comb begin
    state_next   = state;
    acc_next     = acc;
    v_next       = v;
    prod_next    = prod;
    res_a_next   = res_a;
    res_b_next   = res_b;
    mul_sel_next = mul_sel;
    step_next    = step;
    status.busy  = (state != xrp_pkg::SEED_IDLE);
    status.done  = 1'b0;
    unique case (state)
      xrp_pkg::SEED_IDLE: begin
        if (ctrl.start) begin
          acc_next   = seed;
          step_next  = 1'b0;
          state_next = xrp_pkg::SEED_GAMMA;
        end
      end
      xrp_pkg::SEED_GAMMA: begin
        acc_next     = acc_sum;
        v_next       = acc_sum ^ (acc_sum >> 30);
        mul_sel_next = 1'b0;
        state_next   = xrp_pkg::SEED_MUL_LL;
      end
      xrp_pkg::SEED_MUL_LL: begin
        prod_next  = mul_p;
        state_next = xrp_pkg::SEED_MUL_HL;
      end
      xrp_pkg::SEED_MUL_HL: begin
        prod_next[63:32] = prod[63:32] + mul_p[31:0];
        state_next       = xrp_pkg::SEED_MUL_LH;
      end
      xrp_pkg::SEED_MUL_LH: begin
        prod_next[63:32] = prod[63:32] + mul_p[31:0];
        state_next       = xrp_pkg::SEED_POST;
      end
      xrp_pkg::SEED_POST: begin
        if (!mul_sel) begin
          v_next       = prod ^ (prod >> 27);
          mul_sel_next = 1'b1;
          state_next   = xrp_pkg::SEED_MUL_LL;
        end else if (!step) begin
          res_a_next = mix_out;
          step_next  = 1'b1;
          state_next = xrp_pkg::SEED_GAMMA;
        end else begin
          res_b_next = mix_out;
          state_next = xrp_pkg::SEED_DONE;
        end
      end
      xrp_pkg::SEED_DONE: begin
        status.done = 1'b1;
        if (ctrl.ack) begin
          state_next = xrp_pkg::SEED_IDLE;
        end
      end
      default: begin
        state_next = xrp_pkg::SEED_IDLE;
      end
    endcase
  end

  assign words = {res_b, res_a};

endmodule

// ===== rtl/core/xrp_checker.sv =====
// ----------------------------------------------------------------------------
// xrp_checker
// Port-level checks for the xorshift/rotate generator, bound to the top level.
// ----------------------------------------------------------------------------
module xrp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input xrp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input xrp_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_reseed_word_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.was_reseed |-> rsp.word == '0)
    else $error("reseed transaction with nonzero word");

  a_gen_next_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == xrp_pkg::FUNC_GEN)
      |=> rsp_valid && !rsp.was_reseed)
    else $error("generate transaction did not produce a word");

  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == xrp_pkg::FUNC_RESEED) |=> req_stall)
    else $error("req accepted during reseed");

endmodule

bind xorshift_rotate_prng_with_seeding_unit xrp_checker u_xrp_checker (.*);

// ===== dv/xorshift_rotate_prng_with_seeding_unit_tb.sv =====
// ----------------------------------------------------------------------------
// xorshift_rotate_prng_with_seeding_unit_tb
// Self-checking bench for the xorshift/rotate generator with splitmix64 seeding.
// A queue-fed driver sends reseed and generate transactions. A scoreboard
// model of the four state words predicts every response. The monitor checks
// each response in order. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module xorshift_rotate_prng_with_seeding_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM   = 600;
  localparam int unsigned N_PHASES   = 4;
  localparam int unsigned DRAIN_CYC  = 30;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct {
    xrp_pkg::req_t r;
    int unsigned   ph;
  } stim_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          rsp_stall = 1'b0;
  xrp_pkg::req_t req       = '0;
  logic          req_stall;
  logic          rsp_valid;
  xrp_pkg::rsp_t rsp;

  stim_t         stim_q[$];
  xrp_pkg::rsp_t rsp_exp_q[$];
  logic [31:0]   gen_st[4];
  int unsigned   cur_phase = 0;
  int unsigned   errors    = 0;
  int unsigned   n_reseed  = 0;
  int unsigned   n_gen     = 0;
  int unsigned   n_checked = 0;

  xorshift_rotate_prng_with_seeding_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [63:0] mix_out(input logic [63:0] acc);
    logic [63:0] v;
    v = acc;
    v = (v ^ (v >> 30)) * xrp_pkg::MIX_MUL1;
    v = (v ^ (v >> 27)) * xrp_pkg::MIX_MUL2;
    return v ^ (v >> 31);
  endfunction

  // Updates the model state and returns the response the transaction causes.
  function automatic xrp_pkg::rsp_t prng_apply(input xrp_pkg::req_t r);
    xrp_pkg::rsp_t o;
    logic [63:0]   acc;
    logic [63:0]   a;
    logic [63:0]   b;
    logic [31:0]   t;
    if (r.func == xrp_pkg::FUNC_RESEED) begin
      acc = r.seed + xrp_pkg::MIX_GAMMA;
      a = mix_out(acc);
      acc = acc + xrp_pkg::MIX_GAMMA;
      b = mix_out(acc);
      gen_st[0] = a[31:0];
      gen_st[1] = a[63:32];
      gen_st[2] = b[31:0];
      gen_st[3] = b[63:32];
      if ((gen_st[0] | gen_st[1] | gen_st[2] | gen_st[3]) == 32'd0) gen_st[0] = 32'd1;
      o.word = '0;
      o.was_reseed = 1'b1;
    end else begin
      o.word = rotl32(gen_st[0] + gen_st[3], xrp_pkg::OUT_ROT);
      o.was_reseed = 1'b0;
      t = gen_st[1] << xrp_pkg::STATE_SHL;
      gen_st[2] = gen_st[2] ^ gen_st[0];
      gen_st[3] = gen_st[3] ^ gen_st[1];
      gen_st[1] = gen_st[1] ^ gen_st[2];
      gen_st[0] = gen_st[0] ^ gen_st[3];
      gen_st[2] = gen_st[2] ^ t;
      gen_st[3] = rotl32(gen_st[3], xrp_pkg::STATE_ROT);
    end
    return o;
  endfunction

  function automatic int unsigned send_idle_pct(input int unsigned ph);
    case (ph)
      1: return 54;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(input int unsigned ph);
    case (ph)
      2: return 54;
      3: return 21;
      default: return 0;
    endcase
  endfunction

  task automatic push_item(input logic func, input logic [63:0] seed, input int unsigned ph);
    stim_t s;
    s.r.func = func;
    s.r.seed = seed;
    s.ph = ph;
    stim_q.push_back(s);
  endtask

  // Driver
  always @(posedge clk) begin
    stim_t s;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        rsp_exp_q.push_back(prng_apply(req));
        if (req.func == xrp_pkg::FUNC_RESEED) n_reseed++;
        else n_gen++;
      end
      if (stim_q.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct(stim_q[0].ph)) begin
        s = stim_q.pop_front();
        cur_phase = s.ph;
        req <= s.r;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    xrp_pkg::rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_exp_q.size() == 0) begin
          if (errors < MAX_REPORT)
            $display("ERROR: unexpected transaction word=%08h was_reseed=%0b",
                     rsp.word, rsp.was_reseed);
          errors++;
        end else begin
          e = rsp_exp_q.pop_front();
          n_checked++;
          if (rsp.word !== e.word || rsp.was_reseed !== e.was_reseed) begin
            if (errors < MAX_REPORT)
              $display({"ERROR: result %0d exp word=%08h was_reseed=%0b",
                        " got word=%08h was_reseed=%0b"},
                       n_checked, e.word, e.was_reseed, rsp.word, rsp.was_reseed);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct(cur_phase));
    end
  end

  initial begin
    #3600000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [63:0] sd;
    gen_st[0] = 32'd1;
    gen_st[1] = 32'd0;
    gen_st[2] = 32'd0;
    gen_st[3] = 32'd0;

    // directed: reset state, extreme and patterned seeds, back-to-back reseeds
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'h0, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'h5555_5555_5555_5555, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'h8000_0000_0000_0000, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'h0000_0000_0000_0001, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    // seed that wraps the accumulator to zero
    push_item(xrp_pkg::FUNC_RESEED, 64'h0 - xrp_pkg::MIX_GAMMA, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h0, 0);
    push_item(xrp_pkg::FUNC_RESEED, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    push_item(xrp_pkg::FUNC_GEN, 64'h1234_5678_9ABC_DEF0, 0);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 7))
        0: sd = 64'(  $urandom_range(0, 15));
        1: sd = ~64'($urandom_range(0, 15));
        default: sd = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 99) < 12)
        push_item(xrp_pkg::FUNC_RESEED, sd, i * N_PHASES / N_RANDOM);
      else
        push_item(xrp_pkg::FUNC_GEN, sd, i * N_PHASES / N_RANDOM);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() > 0 || req_valid) @(posedge clk);
    while (rsp_exp_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d reseed and %0d generate transactions over %0d flow-control phases.",
             n_reseed, n_gen, N_PHASES);
    $display("Checked %0d responses, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
